// ===== sv/sorted_sample_rank_table_defines.svh =====
// assertion macros used by the sorted sample rank table output stage
`ifndef SORTED_SAMPLE_RANK_TABLE_DEFINES_SVH
`define SORTED_SAMPLE_RANK_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SSRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ssrt_pkg.sv =====
package ssrt_pkg;

    // default sizes
    localparam int DEPTH_DEFAULT      = 64;
    localparam int VALUE_BITS_DEFAULT = 32;

    // width of each count field on the result channel
    localparam int RANK_BITS     = 7;
    localparam int OUT_DATA_BITS = ((2 * RANK_BITS + 7) / 8) * 8;

    // item kinds carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // status codes carried in m_tuser
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // control flags that travel with each item along the row
    typedef struct packed {
        logic valid;
        logic query;
        logic drop;
    } ctl_t;

endpackage

// ===== sv/ssrt_cell.sv =====
module ssrt_cell #(
    parameter int VALUE_BITS = ssrt_pkg::VALUE_BITS_DEFAULT,
    parameter int COUNT_BITS = 7,
    parameter int CELL_INDEX = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  ssrt_pkg::ctl_t               in_ctl,
    input  logic signed [VALUE_BITS-1:0] in_key,
    input  logic [COUNT_BITS-1:0]        in_rank,
    input  logic [COUNT_BITS-1:0]        in_prior,
    output ssrt_pkg::ctl_t               out_ctl,
    output logic signed [VALUE_BITS-1:0] out_key,
    output logic [COUNT_BITS-1:0]        out_rank,
    output logic [COUNT_BITS-1:0]        out_prior
);
    import ssrt_pkg::*;

    localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(CELL_INDEX);

    logic signed [VALUE_BITS-1:0] sample_reg, sample_next;
    ctl_t                         ctl_reg;
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic [COUNT_BITS-1:0]        rank_reg, rank_next;
    logic [COUNT_BITS-1:0]        prior_reg;
    logic                         occupied;

    // cell holds a sample when its index is below the count the item saw at entry
    assign occupied = (IDX < in_prior);

    // compare the passing word with the held sample
    always_comb begin
        sample_next = sample_reg;
        key_next    = in_key;
        rank_next   = in_rank;
        if (in_ctl.valid && in_ctl.query) begin
            if (occupied && (sample_reg <= in_key)) begin
                rank_next = in_rank + 1'b1;
            end
        end else if (in_ctl.valid && !in_ctl.drop) begin
            if (occupied) begin
                // strictly smaller displaces, so an equal value lands after its twins
                if (in_key < sample_reg) begin
                    sample_next = in_key;
                    key_next    = sample_reg;
                end
            end else if (IDX == in_prior) begin
                sample_next = in_key;
            end
        end
    end

    // held sample
    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= sample_next;
        end
    end

    // item control to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    // item payload to the neighbor
    always_ff @(posedge aclk) begin
        if (en) begin
            key_reg   <= key_next;
            rank_reg  <= rank_next;
            prior_reg <= in_prior;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_key   = key_reg;
    assign out_rank  = rank_reg;
    assign out_prior = prior_reg;

endmodule

// ===== sv/ssrt_out_stage.sv =====
`include "sorted_sample_rank_table_defines.svh"

module ssrt_out_stage #(
    parameter int TABLE_DEPTH = ssrt_pkg::DEPTH_DEFAULT,
    parameter int COUNT_BITS  = 7
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ssrt_pkg::ctl_t                     in_ctl,
    input  logic [COUNT_BITS-1:0]              in_rank,
    input  logic [COUNT_BITS-1:0]              in_prior,
    input  logic                               complementary,
    output logic                               chain_en,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rank_count [6:0], total_count [13:7], zero fill above
    output logic [ssrt_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // status [0]
    output logic                               m_tuser
);
    import ssrt_pkg::*;

    localparam logic [COUNT_BITS-1:0] DEPTH_CNT = COUNT_BITS'(TABLE_DEPTH);

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [COUNT_BITS-1:0]          rank_reg, rank_next;
    logic [COUNT_BITS-1:0]          total_reg, total_next;
    logic                           status_reg, status_next;
    logic                           load;
    logic [COUNT_BITS+RANK_BITS-1:0] rank_wide;
    logic [COUNT_BITS+RANK_BITS-1:0] total_wide;

    // the row stalls only when its last word cannot move into the output register
    assign load     = in_ctl.valid && (!m_tvalid_reg || m_tready);
    assign chain_en = !(in_ctl.valid && m_tvalid_reg && !m_tready);

    // final counts for the word leaving the row
    always_comb begin
        total_next  = in_prior + COUNT_BITS'(!in_ctl.query && !in_ctl.drop);
        rank_next   = '0;
        status_next = STATUS_OK;
        if (in_ctl.query) begin
            rank_next = complementary ? (total_next - in_rank) : in_rank;
        end else if (in_ctl.drop) begin
            status_next = STATUS_DROPPED;
        end
    end

    // output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            rank_reg   <= rank_next;
            total_reg  <= total_next;
            status_reg <= status_next;
        end
    end

    // counts are cut to the field width
    assign rank_wide  = {RANK_BITS'(0), rank_reg};
    assign total_wide = {RANK_BITS'(0), total_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_BITS'({total_wide[RANK_BITS-1:0], rank_wide[RANK_BITS-1:0]});
    assign m_tuser  = status_reg;

    // checks
    `SSRT_ASSERT_NOW(a_drop_only_when_full, aclk, aresetn,
        m_tvalid_reg && (status_reg == STATUS_DROPPED), total_reg == DEPTH_CNT,
        "dropped insert reported while table not full")
    `SSRT_ASSERT_NOW(a_drop_has_zero_rank, aclk, aresetn,
        m_tvalid_reg && (status_reg == STATUS_DROPPED), rank_reg == '0,
        "dropped insert reported a nonzero rank")
    `SSRT_ASSERT_NOW(a_rank_within_total, aclk, aresetn,
        m_tvalid_reg, rank_reg <= total_reg,
        "rank exceeds the stored sample count")
    `SSRT_ASSERT_NEXT(a_last_word_held, aclk, aresetn,
        in_ctl.valid && m_tvalid_reg && !m_tready, in_ctl.valid && $stable(in_prior),
        "last word of the row moved while output was stalled")

endmodule

// ===== sv/sorted_sample_rank_table.sv =====
// sorted sample rank table
// s_ channel: one word per item; s_tuser picks insert (0) or query (1), s_tdata
// carries the signed fixed-point sample or query point.
// m_ channel: one word per item, in order; m_tdata holds the rank count and the
// number of stored samples, m_tuser flags an insert dropped on a full table.
// cfg channel: a one-bit write that selects the complementary rank (samples
// strictly above the point); cfg_ready is always high.
// the samples sit in a row of TABLE_DEPTH cells kept in ascending order; every
// item walks the row one cell per cycle while not frozen, an insert pushing
// larger samples along, a query gathering its count as it passes.
// from acceptance an item passes every cell and then the output register.
// throughput: one item per cycle unless frozen, set by the row's cell step.
// reset empties the table and clears the complementary setting; no clearing pass.
// when the receiver stalls, the row freezes only once a finished word waits in
// the output register and another has reached the last cell; until then new
// items are still taken.
module sorted_sample_rank_table #(
    parameter int TABLE_DEPTH = ssrt_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS  = ssrt_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value [VALUE_BITS-1:0], zero fill above
    input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,
    // mode [0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // rank_count [6:0], total_count [13:7], zero fill above
    output logic [ssrt_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // status [0]
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);
    import ssrt_pkg::*;

    localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] DEPTH_CNT = COUNT_BITS'(TABLE_DEPTH);

    logic                          complementary_reg;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic                          s_accept;
    logic                          chain_en;
    logic                          full;

    ctl_t                          row_ctl   [0:TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0]  row_key   [0:TABLE_DEPTH];
    logic [COUNT_BITS-1:0]         row_rank  [0:TABLE_DEPTH];
    logic [COUNT_BITS-1:0]         row_prior [0:TABLE_DEPTH];

    assign s_tready  = chain_en;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign full      = (count_reg >= DEPTH_CNT);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            complementary_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            complementary_reg <= cfg_data;
        end
    end

    // stored sample count, bumped when an insert is taken into a table with room
    always_comb begin
        count_next = count_reg;
        if (s_accept && (s_tuser == MODE_INSERT) && !full) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // item entering the row
    assign row_ctl[0].valid = s_accept;
    assign row_ctl[0].query = (s_tuser == MODE_QUERY);
    assign row_ctl[0].drop  = (s_tuser == MODE_INSERT) && full;
    assign row_key[0]       = $signed(s_tdata[VALUE_BITS-1:0]);
    assign row_rank[0]      = '0;
    assign row_prior[0]     = count_reg;

    // row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ssrt_cell #(
            .VALUE_BITS (VALUE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (chain_en),
            .in_ctl    (row_ctl[i]),
            .in_key    (row_key[i]),
            .in_rank   (row_rank[i]),
            .in_prior  (row_prior[i]),
            .out_ctl   (row_ctl[i+1]),
            .out_key   (row_key[i+1]),
            .out_rank  (row_rank[i+1]),
            .out_prior (row_prior[i+1])
        );
    end

    // result register and handshake
    ssrt_out_stage #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_ctl        (row_ctl[TABLE_DEPTH]),
        .in_rank       (row_rank[TABLE_DEPTH]),
        .in_prior      (row_prior[TABLE_DEPTH]),
        .complementary (complementary_reg),
        .chain_en      (chain_en),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
